// ----- src/stx_etx_length_frame_parser_defines.svh -----
// Assertion macros used by the checker file of the frame parser.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef STX_ETX_LENGTH_FRAME_PARSER_DEFINES_SVH
`define STX_ETX_LENGTH_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sefp_pkg.sv -----
// Shared types, codes and the identifier table of the STX/ETX frame parser.
// No dependencies.
package sefp_pkg;

    localparam int ID_COUNT = 23;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_CODE  = 2'd0;
    localparam logic [1:0] CFG_END_CODE    = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;
    localparam logic [1:0] CFG_DISC_TMO    = 2'd3;

    // Result event kinds.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PAYLOAD = 3'd1;
    localparam logic [2:0] EV_ACCEPT  = 3'd2;
    localparam logic [2:0] EV_REJECT  = 3'd3;
    localparam logic [2:0] EV_RESYNC  = 3'd4;

    // Reject reasons.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_START = 3'd1;
    localparam logic [2:0] ERR_BAD_LEN  = 3'd2;
    localparam logic [2:0] ERR_NO_END   = 3'd3;
    localparam logic [2:0] ERR_BAD_ID   = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG = 3'd5;

    // Header byte positions.
    localparam logic [2:0] HDR_START   = 3'd0;
    localparam logic [2:0] HDR_LAST_DIGIT = 3'd3;
    localparam logic [2:0] HDR_ID0     = 3'd4;
    localparam logic [2:0] HDR_LAST    = 3'd5;

    localparam logic [15:0] ID_TABLE [ID_COUNT] = '{
        "PG", "PS", "VS", "VE", "SG", "DG",
        "CG", "CS", "CN", "CR", "TS", "TG",
        "M0", "M1", "M2", "M3", "M4", "M5",
        "M6", "M7", "M8", "M9", "MA"
    };

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_END,
        PH_DISCARD
    } phase_t;

    typedef struct packed {
        logic [7:0]  start_code;
        logic [7:0]  end_code;
        logic [9:0]  max_payload_length;
        logic [15:0] discard_timeout;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_tick;
    } item_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] payload_byte;
        logic       last_payload;
        logic [4:0] command_index;
        logic [2:0] error_code;
        logic       resync_by_timeout;
    } result_t;

    typedef struct packed {
        logic       found;
        logic [4:0] index;
    } id_hit_t;

    // Parallel compare of the two identifier bytes against the code table.
    function automatic id_hit_t id_lookup(input logic [7:0] c0, input logic [7:0] c1);
        id_hit_t hit;
        hit = '0;
        for (int i = 0; i < ID_COUNT; i++) begin
            if (!hit.found && ID_TABLE[i] == {c0, c1}) begin
                hit.found = 1'b1;
                hit.index = 5'(i);
            end
        end
        return hit;
    endfunction

endpackage

// ----- src/sefp_cfg_regs.sv -----
// Configuration register bank of the frame parser.
// Depends on sefp_pkg.
module sefp_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output sefp_pkg::cfg_t    cfg
);
    import sefp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code         <= 8'd2;
            cfg_reg.end_code           <= 8'd3;
            cfg_reg.max_payload_length <= 10'd255;
            cfg_reg.discard_timeout    <= 16'd500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_CODE: cfg_reg.start_code         <= cfg_data[7:0];
                CFG_END_CODE:   cfg_reg.end_code           <= cfg_data[7:0];
                CFG_MAX_LENGTH: cfg_reg.max_payload_length <= cfg_data[9:0];
                CFG_DISC_TMO:   cfg_reg.discard_timeout    <= cfg_data;
                default:        cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/sefp_in_stage.sv -----
// Input register of the frame parser: holds one accepted item until it moves on.
// Depends on sefp_pkg.
module sefp_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sefp_pkg::item_t in_item,
    input  logic            advance,
    output logic            item_valid,
    output sefp_pkg::item_t item
);
    import sefp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // Stall only while a held item cannot move on this cycle.
    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- src/sefp_core.sv -----
// Frame parsing state and the one-step update applied to each item.
// Depends on sefp_pkg.
module sefp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  sefp_pkg::cfg_t    cfg,
    input  sefp_pkg::item_t   item,
    input  logic              advance,
    output sefp_pkg::result_t result
);
    import sefp_pkg::*;

    phase_t      phase_reg,        phase_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic        header_ok_reg,    header_ok_next;
    logic        start_bad_reg,    start_bad_next;
    logic [9:0]  length_accum_reg, length_accum_next;
    logic [7:0]  id0_reg,          id0_next;
    logic [7:0]  id1_reg,          id1_next;
    logic [9:0]  payload_left_reg, payload_left_next;
    logic [15:0] discard_ticks_reg, discard_ticks_next;

    logic [16:0] ticks_inc;
    logic [12:0] len_sum;
    logic [3:0]  digit;
    logic        last;
    id_hit_t     hit;
    result_t     res;

    assign ticks_inc = {1'b0, discard_ticks_reg} + 17'd1;
    assign digit     = 4'(item.rx_byte - 8'h30);
    assign len_sum   = {length_accum_reg, 3'b000} + {2'b00, length_accum_reg, 1'b0}
                     + {9'd0, digit};
    assign last      = (payload_left_reg <= 10'd1);
    assign hit       = id_lookup(id0_reg, id1_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        header_ok_next     = header_ok_reg;
        start_bad_next     = start_bad_reg;
        length_accum_next  = length_accum_reg;
        id0_next           = id0_reg;
        id1_next           = id1_reg;
        payload_left_next  = payload_left_reg;
        discard_ticks_next = discard_ticks_reg;
        res                = '0;

        if (phase_reg == PH_DISCARD)
        begin
            if (item.is_tick)
            begin
                if (ticks_inc > {1'b0, cfg.discard_timeout})
                begin
                    phase_next            = PH_HEADER;
                    header_count_next     = HDR_START;
                    discard_ticks_next    = '0;
                    res.event_kind        = EV_RESYNC;
                    res.resync_by_timeout = 1'b1;
                end
                else
                begin
                    discard_ticks_next = ticks_inc[15:0];
                end
            end
            else if (item.rx_byte == cfg.end_code)
            begin
                phase_next         = PH_HEADER;
                header_count_next  = HDR_START;
                discard_ticks_next = '0;
                res.event_kind     = EV_RESYNC;
            end
        end
        else if (!item.is_tick)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (header_count_reg == HDR_START)
                    begin
                        header_ok_next    = (item.rx_byte == cfg.start_code);
                        start_bad_next    = (item.rx_byte != cfg.start_code);
                        length_accum_next = '0;
                    end
                    else if (header_count_reg <= HDR_LAST_DIGIT)
                    begin
                        if (item.rx_byte inside {[8'h30:8'h39]})
                        begin
                            length_accum_next = len_sum[9:0];
                        end
                        else
                        begin
                            header_ok_next = 1'b0;
                        end
                    end
                    else if (header_count_reg == HDR_ID0)
                    begin
                        id0_next = item.rx_byte;
                    end
                    else
                    begin
                        id1_next = item.rx_byte;
                    end

                    if (header_count_reg == HDR_LAST)
                    begin
                        // Judge the header once all six bytes are in.
                        header_count_next = HDR_START;
                        if (!header_ok_reg)
                        begin
                            res.event_kind     = EV_REJECT;
                            res.error_code     = start_bad_reg ? ERR_NO_START : ERR_BAD_LEN;
                            phase_next         = PH_DISCARD;
                            discard_ticks_next = '0;
                        end
                        else if (length_accum_reg > cfg.max_payload_length)
                        begin
                            res.event_kind     = EV_REJECT;
                            res.error_code     = ERR_TOO_LONG;
                            phase_next         = PH_DISCARD;
                            discard_ticks_next = '0;
                        end
                        else if (length_accum_reg == '0)
                        begin
                            phase_next = PH_END;
                        end
                        else
                        begin
                            payload_left_next = length_accum_reg;
                            phase_next        = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        header_count_next = header_count_reg + 3'd1;
                    end
                end

                PH_PAYLOAD:
                begin
                    res.event_kind    = EV_PAYLOAD;
                    res.payload_byte  = item.rx_byte;
                    res.last_payload  = last;
                    payload_left_next = last ? 10'd0 : payload_left_reg - 10'd1;
                    if (last)
                    begin
                        phase_next = PH_END;
                    end
                end

                PH_END:
                begin
                    if (item.rx_byte != cfg.end_code)
                    begin
                        res.event_kind     = EV_REJECT;
                        res.error_code     = ERR_NO_END;
                        phase_next         = PH_DISCARD;
                        discard_ticks_next = '0;
                    end
                    else
                    begin
                        phase_next        = PH_HEADER;
                        header_count_next = HDR_START;
                        if (hit.found)
                        begin
                            res.event_kind    = EV_ACCEPT;
                            res.command_index = hit.index;
                        end
                        else
                        begin
                            res.event_kind = EV_REJECT;
                            res.error_code = ERR_BAD_ID;
                        end
                    end
                end

                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= HDR_START;
            header_ok_reg     <= 1'b1;
            start_bad_reg     <= 1'b0;
            length_accum_reg  <= '0;
            id0_reg           <= '0;
            id1_reg           <= '0;
            payload_left_reg  <= '0;
            discard_ticks_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            header_ok_reg     <= header_ok_next;
            start_bad_reg     <= start_bad_next;
            length_accum_reg  <= length_accum_next;
            id0_reg           <= id0_next;
            id1_reg           <= id1_next;
            payload_left_reg  <= payload_left_next;
            discard_ticks_reg <= discard_ticks_next;
        end
    end

    assign result = res;

endmodule

// ----- src/sefp_out_stage.sv -----
// Result register with a skid entry, so a stalled receiver does not stop intake until the skid entry is full.
// Depends on sefp_pkg.
module sefp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sefp_pkg::result_t push_data,
    output logic              can_accept,
    output logic              out_valid,
    input  logic              out_stall,
    output sefp_pkg::result_t out_data
);
    import sefp_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;
    logic    load_main;
    logic    load_skid;

    assign pop        = main_valid_reg && !out_stall;
    assign can_accept = !skid_valid_reg;
    assign load_main  = !skid_valid_reg && push && (!main_valid_reg || pop);
    assign load_skid  = !skid_valid_reg && push && main_valid_reg && !pop;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (load_main)
        begin
            main_valid_next = 1'b1;
        end
        else if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && pop)
        begin
            main_reg <= skid_reg;
        end
        else if (load_main)
        begin
            main_reg <= push_data;
        end
        if (load_skid)
        begin
            skid_reg <= push_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ----- src/stx_etx_length_frame_parser.sv -----
// STX/ETX length-prefixed frame parser: top level.
// Depends on sefp_pkg, sefp_cfg_regs, sefp_in_stage, sefp_core, sefp_out_stage.
//
// Usage:
//   The input channel carries one item per handshake: a received byte, or a
//   time tick when is_tick is high. Every accepted item yields exactly one
//   result item on the output channel, in order; event_kind tells what it is
//   (none, payload byte, frame accepted, frame rejected, resync finished).
//   An accepted item sits in the input register, runs through the
//   combinational parse step and is loaded into the result register, which
//   drives the outputs. Throughput is one item per cycle while the result
//   path has room, set by the single parse step between the input register
//   and the result register.
//   When the receiver stalls, the result register holds and a skid entry
//   takes one more result. in_stall is high in every cycle in which the skid
//   entry is full and an item is held.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle; the user is bound to this, the block itself
//   does not enforce it. Reset clears the pipeline, returns the parser to
//   header collection and loads the register defaults (start 2, end 3,
//   maximum length 255, discard timeout 500 ticks).
module stx_etx_length_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        is_tick,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  payload_byte,
    output logic        last_payload,
    output logic [4:0]  command_index,
    output logic [2:0]  error_code,
    output logic        resync_by_timeout
);
    import sefp_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    can_accept;
    logic    advance;
    result_t step_result;
    result_t out_data;

    assign in_item.rx_byte = rx_byte;
    assign in_item.is_tick = is_tick;

    // Move the held item into the result path whenever there is room.
    assign advance = item_valid && can_accept;

    sefp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sefp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parse state advances only together with the result it produces.
    sefp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .advance(advance),
        .result (step_result)
    );

    sefp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (advance),
        .push_data  (step_result),
        .can_accept (can_accept),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    assign event_kind        = out_data.event_kind;
    assign payload_byte      = out_data.payload_byte;
    assign last_payload      = out_data.last_payload;
    assign command_index     = out_data.command_index;
    assign error_code        = out_data.error_code;
    assign resync_by_timeout = out_data.resync_by_timeout;

endmodule

// ----- src/sefp_checker.sv -----
// Port-level checks of the frame parser, bound to the top level.
// Depends on sefp_pkg and stx_etx_length_frame_parser_defines.svh.
`include "stx_etx_length_frame_parser_defines.svh"

module sefp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] event_kind,
    input logic [7:0] payload_byte,
    input logic       last_payload,
    input logic [4:0] command_index,
    input logic [2:0] error_code
);
    import sefp_pkg::*;

    `SEFP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
    `SEFP_ASSERT_NOW(a_rise_needs_item, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without item")
    `SEFP_ASSERT_NOW(a_payload_clean, out_valid && event_kind != EV_PAYLOAD, payload_byte == 8'd0 && last_payload == 1'b0, "payload fields set off payload event")
    `SEFP_ASSERT_NOW(a_reject_coded, out_valid && event_kind == EV_REJECT, error_code != ERR_NONE && error_code <= ERR_TOO_LONG && command_index == 5'd0, "bad reject fields")

endmodule

bind stx_etx_length_frame_parser sefp_checker u_sefp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .payload_byte  (payload_byte),
    .last_payload  (last_payload),
    .command_index (command_index),
    .error_code    (error_code)
);
